>>> design/dfrm_pkg.sv
package dfrm_pkg;

   // Header layout
   localparam int HEADER_BYTES = 9;
   localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

   // Payload length limits
   localparam int LEN_W = 25;
   localparam logic [LEN_W-1:0] DEFAULT_MAX = LEN_W'(16 * 1024 * 1024);
   localparam logic [LEN_W-1:0] LIMIT_MAX   =
      LEN_W'(16 * 1024 * 1024 + 256 * 2 + 65536 + 64);

   // Configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LEN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_LENGTH  = 2'd2;

   // Byte classes handed from the front end to the back end
   localparam int TAG_W = 4;
   localparam logic [TAG_W-1:0] TAG_MAGIC0  = 4'd0;
   localparam logic [TAG_W-1:0] TAG_MAGIC1  = 4'd1;
   localparam logic [TAG_W-1:0] TAG_VERSION = 4'd2;
   localparam logic [TAG_W-1:0] TAG_FLAGS   = 4'd3;
   localparam logic [TAG_W-1:0] TAG_OPCODE  = 4'd4;
   localparam logic [TAG_W-1:0] TAG_LEN0    = 4'd5;
   localparam logic [TAG_W-1:0] TAG_LEN1    = 4'd6;
   localparam logic [TAG_W-1:0] TAG_LEN2    = 4'd7;
   localparam logic [TAG_W-1:0] TAG_LEN3    = 4'd8;
   localparam logic [TAG_W-1:0] TAG_SKIP    = 4'd9;
   localparam logic [TAG_W-1:0] TAG_PAYLOAD = 4'd10;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Result bus
   localparam int RSP_FIELDS_W = 8 + 8 + LEN_W + 8 + 2;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [7:0]       data;
      logic             hdr_done;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic [7:0]       magic_first;
      logic [7:0]       magic_second;
      logic [7:0]       expected_version;
      logic [LEN_W-1:0] length_limit;
   } cfg_type;

endpackage

>>> design/dfrm_front.sv
module dfrm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   output logic                push_valid,
   input  logic                push_ready,
   output dfrm_pkg::entry_type push_entry
);

   localparam logic PH_HEADER  = 1'b0;
   localparam logic PH_PAYLOAD = 1'b1;

   logic                                phase_ff, phase_in;
   logic [dfrm_pkg::HDR_IDX_W-1:0]      idx_ff, idx_in;
   logic [dfrm_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [dfrm_pkg::LEN_W-1:0]          rem_ff, rem_in;
   logic [dfrm_pkg::LEN_W-1:0]          rem_dec;
   logic [dfrm_pkg::LEN_W-1:0]          len_next;
   logic                                accept;
   dfrm_pkg::entry_type                 entry;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid & push_ready;
   assign push_entry = entry;
   assign rem_dec    = rem_ff - dfrm_pkg::LEN_W'(1);

   always_comb begin
      entry.tag      = dfrm_pkg::TAG_SKIP;
      entry.data     = req_tdata;
      entry.hdr_done = 1'b0;
      entry.last     = 1'b0;
      len_next       = len_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      len_in         = len_ff;
      rem_in         = rem_ff;

      if (phase_ff == PH_PAYLOAD) begin
         entry.tag  = dfrm_pkg::TAG_PAYLOAD;
         entry.last = (rem_dec == '0);
      end else begin
         case (idx_ff)
            dfrm_pkg::HDR_IDX_W'(0): entry.tag = dfrm_pkg::TAG_MAGIC0;
            dfrm_pkg::HDR_IDX_W'(1): entry.tag = dfrm_pkg::TAG_MAGIC1;
            dfrm_pkg::HDR_IDX_W'(2): entry.tag = dfrm_pkg::TAG_VERSION;
            dfrm_pkg::HDR_IDX_W'(3): entry.tag = dfrm_pkg::TAG_FLAGS;
            dfrm_pkg::HDR_IDX_W'(4): entry.tag = dfrm_pkg::TAG_OPCODE;
            dfrm_pkg::HDR_IDX_W'(5): entry.tag = dfrm_pkg::TAG_LEN0;
            dfrm_pkg::HDR_IDX_W'(6): entry.tag = dfrm_pkg::TAG_LEN1;
            dfrm_pkg::HDR_IDX_W'(7): entry.tag = dfrm_pkg::TAG_LEN2;
            dfrm_pkg::HDR_IDX_W'(8): entry.tag = dfrm_pkg::TAG_LEN3;
            default:                 entry.tag = dfrm_pkg::TAG_SKIP;
         endcase
         entry.hdr_done = (idx_ff == dfrm_pkg::HDR_IDX_W'(dfrm_pkg::HEADER_BYTES - 1));
      end

      // Track the length locally to count payload bytes; range checks live downstream
      case (entry.tag)
         dfrm_pkg::TAG_LEN0: len_next = dfrm_pkg::LEN_W'(req_tdata);
         dfrm_pkg::TAG_LEN1: len_next[15:8]  = req_tdata;
         dfrm_pkg::TAG_LEN2: len_next[23:16] = req_tdata;
         dfrm_pkg::TAG_LEN3: len_next[24]    = req_tdata[0];
         default:            len_next = len_ff;
      endcase

      if (accept) begin
         len_in = len_next;
         if (phase_ff == PH_PAYLOAD) begin
            rem_in = rem_dec;
            if (entry.last) begin
               phase_in = PH_HEADER;
               idx_in   = '0;
            end
         end else if (entry.hdr_done) begin
            idx_in = '0;
            if (len_next != '0) begin
               phase_in = PH_PAYLOAD;
               rem_in   = len_next;
            end
         end else begin
            idx_in = idx_ff + dfrm_pkg::HDR_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         idx_ff   <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

>>> design/dfrm_fifo.sv
module dfrm_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  dfrm_pkg::entry_type wr_entry,
   output logic                rd_valid,
   input  logic                rd_ready,
   output dfrm_pkg::entry_type rd_entry
);

   dfrm_pkg::entry_type                 slot_ff [dfrm_pkg::QUEUE_DEPTH];
   logic [dfrm_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [dfrm_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [dfrm_pkg::QPTR_W:0]           count_ff, count_in;
   logic                                push;
   logic                                pop;

   assign wr_ready = (count_ff != (dfrm_pkg::QPTR_W+1)'(dfrm_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + dfrm_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + dfrm_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (dfrm_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (dfrm_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/dfrm_back.sv
module dfrm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  dfrm_pkg::cfg_type                 cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  dfrm_pkg::entry_type               pop_entry,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dfrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   logic                          err_ff, err_in;
   logic [7:0]                    flags_ff, flags_in;
   logic [7:0]                    opcode_ff, opcode_in;
   logic [dfrm_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                          valid_ff, valid_in;
   logic [1:0]                    kind_ff, kind_in;
   logic [7:0]                    o_flags_ff, o_flags_in;
   logic [7:0]                    o_opcode_ff, o_opcode_in;
   logic [dfrm_pkg::LEN_W-1:0]    o_len_ff, o_len_in;
   logic [7:0]                    o_byte_ff, o_byte_in;
   logic                          o_last_ff, o_last_in;
   logic [1:0]                    o_code_ff, o_code_in;
   logic                          take;
   logic                          emit;
   logic                          fail;
   logic [1:0]                    fail_code;
   logic                          len_high;

   assign pop_ready = ~valid_ff | rsp_tready;
   assign take      = pop_valid & pop_ready;
   // Length bits 25..31 come from the top byte; any of them set is over every limit
   assign len_high  = |pop_entry.data[7:1];

   always_comb begin
      err_in      = err_ff;
      flags_in    = flags_ff;
      opcode_in   = opcode_ff;
      len_in      = len_ff;
      fail        = 1'b0;
      fail_code   = dfrm_pkg::ERR_MAGIC;
      emit        = 1'b0;
      kind_in     = kind_ff;
      o_flags_in  = o_flags_ff;
      o_opcode_in = o_opcode_ff;
      o_len_in    = o_len_ff;
      o_byte_in   = o_byte_ff;
      o_last_in   = o_last_ff;
      o_code_in   = o_code_ff;

      if (take && !err_ff) begin
         case (pop_entry.tag)
            dfrm_pkg::TAG_MAGIC0: begin
               fail = (pop_entry.data != cfg.magic_first);
            end
            dfrm_pkg::TAG_MAGIC1: begin
               fail = (pop_entry.data != cfg.magic_second);
            end
            dfrm_pkg::TAG_VERSION: begin
               fail      = (pop_entry.data != cfg.expected_version);
               fail_code = dfrm_pkg::ERR_VERSION;
            end
            dfrm_pkg::TAG_FLAGS:  flags_in  = pop_entry.data;
            dfrm_pkg::TAG_OPCODE: opcode_in = pop_entry.data;
            dfrm_pkg::TAG_LEN0:   len_in    = dfrm_pkg::LEN_W'(pop_entry.data);
            dfrm_pkg::TAG_LEN1:   len_in[15:8]  = pop_entry.data;
            dfrm_pkg::TAG_LEN2:   len_in[23:16] = pop_entry.data;
            dfrm_pkg::TAG_LEN3: begin
               len_in[24] = pop_entry.data[0];
               fail       = len_high | (len_in > cfg.length_limit);
               fail_code  = dfrm_pkg::ERR_LENGTH;
            end
            default: begin
            end
         endcase

         if (fail) begin
            err_in      = 1'b1;
            emit        = 1'b1;
            kind_in     = dfrm_pkg::KIND_ERROR;
            o_flags_in  = '0;
            o_opcode_in = '0;
            o_len_in    = '0;
            o_byte_in   = '0;
            o_last_in   = 1'b0;
            o_code_in   = fail_code;
         end else if (pop_entry.tag == dfrm_pkg::TAG_PAYLOAD) begin
            emit        = 1'b1;
            kind_in     = dfrm_pkg::KIND_PAYLOAD;
            o_flags_in  = flags_ff;
            o_opcode_in = opcode_ff;
            o_len_in    = len_ff;
            o_byte_in   = pop_entry.data;
            o_last_in   = pop_entry.last;
            o_code_in   = dfrm_pkg::ERR_MAGIC;
         end else if (pop_entry.hdr_done) begin
            emit        = 1'b1;
            kind_in     = dfrm_pkg::KIND_HEADER;
            o_flags_in  = flags_in;
            o_opcode_in = opcode_in;
            o_len_in    = len_in;
            o_byte_in   = '0;
            o_last_in   = (len_in == '0);
            o_code_in   = dfrm_pkg::ERR_MAGIC;
         end
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff    <= 1'b0;
         flags_ff  <= '0;
         opcode_ff <= '0;
         len_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         err_ff    <= err_in;
         flags_ff  <= flags_in;
         opcode_ff <= opcode_in;
         len_ff    <= len_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      o_flags_ff  <= o_flags_in;
      o_opcode_ff <= o_opcode_in;
      o_len_ff    <= o_len_in;
      o_byte_ff   <= o_byte_in;
      o_last_ff   <= o_last_in;
      o_code_ff   <= o_code_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = dfrm_pkg::RSP_TDATA_W'({o_code_ff, o_byte_ff, o_len_ff,
                                               o_opcode_ff, o_flags_ff});

endmodule

>>> design/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer. Bytes enter one per transaction on req_ and
// are split into headers (two magic bytes, version, flags, opcode, 32-bit
// little-endian payload length) and payload bytes. Each completed header gives
// one kind 0 result carrying flags, opcode and length, tlast set when the
// payload is empty; each payload byte gives one kind 1 result, tlast on the
// final byte. A magic or version mismatch, or a length above the length limit
// register, gives a single kind 2 error result; every later byte is dropped
// until reset. Throughput is one byte per clock with no bubbles between frames
// while rsp_tready stays high. A byte passes through the two-entry queue
// between the classifying front end and the checking back end, then the
// output register, before its result is presented on rsp_. With rsp_tready
// low the queue and the output register absorb three bytes before req_tready
// drops. Write the csr_ registers only while the block is drained.
module length_prefixed_frame_deframer_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [7:0] data_byte
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // rsp_tdata: [7:0] frame_flags, [15:8] opcode, [40:16] payload_length,
   //            [48:41] payload_byte, [50:49] error_code, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dfrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [dfrm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dfrm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dfrm_pkg::cfg_type     cfg_ff, cfg_in;
   dfrm_pkg::entry_type   push_entry;
   dfrm_pkg::entry_type   pop_entry;
   logic                  push_valid;
   logic                  push_ready;
   logic                  pop_valid;
   logic                  pop_ready;

   // Register file; the length limit maps zero to the default and clamps at the ceiling
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dfrm_pkg::CSR_MAGIC_FIRST:  cfg_in.magic_first      = csr_wdata[7:0];
            dfrm_pkg::CSR_MAGIC_SECOND: cfg_in.magic_second     = csr_wdata[7:0];
            dfrm_pkg::CSR_VERSION:      cfg_in.expected_version = csr_wdata[7:0];
            dfrm_pkg::CSR_LENGTH_LIMIT: begin
               if (csr_wdata == '0) begin
                  cfg_in.length_limit = dfrm_pkg::DEFAULT_MAX;
               end else if (csr_wdata > dfrm_pkg::LIMIT_MAX) begin
                  cfg_in.length_limit = dfrm_pkg::LIMIT_MAX;
               end else begin
                  cfg_in.length_limit = csr_wdata;
               end
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first      <= '0;
         cfg_ff.magic_second     <= '0;
         cfg_ff.expected_version <= '0;
         cfg_ff.length_limit     <= dfrm_pkg::DEFAULT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: track header position and payload count, tag each byte
   dfrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Queue decouples the front end from output backpressure
   dfrm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_entry (pop_entry)
   );

   // Back end: check header fields, hold frame info, latch sticky error, drive results
   dfrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/length_prefixed_frame_deframer_top_tb.sv
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_top_tb;

   // Settle time after the last expected result before touching the csr_
   // port or ending the run.
   localparam int SETTLE_CYCLES = 8;
   // About 1200 bytes with sender gaps or receiver stalls at up to 76 percent,
   // plus settling, well within the limit.
   localparam int CYCLE_LIMIT   = 100000;
   localparam int PHASE_BYTES   = 108;
   localparam int PHASE_COUNT   = 8;
   localparam int NOISE_BYTES   = 40;

   // rsp_tdata layout, lowest bit up
   localparam int FLAGS_LSB  = 0;
   localparam int OPCODE_LSB = 8;
   localparam int LENGTH_LSB = 16;
   localparam int PBYTE_LSB  = 41;
   localparam int ECODE_LSB  = 49;
   localparam int PAD_LSB    = 51;

   typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_ERROR} deframe_state_type;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [7:0]                 flags;
      logic [7:0]                 opcode;
      logic [dfrm_pkg::LEN_W-1:0] length;
      logic [7:0]                 payload_byte;
      logic                       last;
      logic [1:0]                 error_code;
   } deframe_result_type;

   typedef logic [7:0] byte_q_type[$];

   // Tracks the deframer state byte by byte, queues the result each
   // accepted byte should produce and checks results in order.
   class deframe_scoreboard_type;
      logic [7:0]                 magic_first  = 8'h00;
      logic [7:0]                 magic_second = 8'h00;
      logic [7:0]                 version      = 8'h00;
      logic [dfrm_pkg::LEN_W-1:0] max_length   = dfrm_pkg::DEFAULT_MAX;

      deframe_state_type          state        = ST_HEADER;
      int unsigned                hdr_pos      = 0;
      logic [7:0]                 held_flags   = 8'h00;
      logic [7:0]                 held_opcode  = 8'h00;
      logic [31:0]                length_acc   = '0;
      logic [dfrm_pkg::LEN_W-1:0] remaining    = '0;

      deframe_result_type         awaited_results[$];
      int unsigned                mismatch_count = 0;
      int unsigned                checked_count  = 0;
      int unsigned                header_count   = 0;

      function void set_register(logic [dfrm_pkg::CSR_IDX_W-1:0] idx,
                                 logic [dfrm_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            dfrm_pkg::CSR_MAGIC_FIRST:  magic_first  = value[7:0];
            dfrm_pkg::CSR_MAGIC_SECOND: magic_second = value[7:0];
            dfrm_pkg::CSR_VERSION:      version      = value[7:0];
            dfrm_pkg::CSR_LENGTH_LIMIT: begin
               // zero falls back to the default, oversize clamps to the ceiling
               if (value == '0)
                  max_length = dfrm_pkg::DEFAULT_MAX;
               else if (value > dfrm_pkg::LIMIT_MAX)
                  max_length = dfrm_pkg::LIMIT_MAX;
               else
                  max_length = value;
            end
            default: ;
         endcase
      endfunction

      function void raise_error(logic [1:0] code);
         deframe_result_type r;
         r = '0;
         r.kind = dfrm_pkg::KIND_ERROR;
         r.error_code = code;
         state = ST_ERROR;
         awaited_results.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b);
         deframe_result_type r;
         r = '0;
         if (state == ST_PAYLOAD) begin
            remaining = remaining - dfrm_pkg::LEN_W'(1);
            r.kind = dfrm_pkg::KIND_PAYLOAD;
            r.flags = held_flags;
            r.opcode = held_opcode;
            r.length = length_acc[dfrm_pkg::LEN_W-1:0];
            r.payload_byte = b;
            r.last = (remaining == '0);
            awaited_results.push_back(r);
            if (r.last) begin
               state = ST_HEADER;
               hdr_pos = 0;
            end
            return;
         end
         // sticky error: drop everything until reset
         if (state != ST_HEADER)
            return;

         case (hdr_pos)
            0: begin
               if (b != magic_first) begin
                  raise_error(dfrm_pkg::ERR_MAGIC);
                  return;
               end
            end
            1: begin
               if (b != magic_second) begin
                  raise_error(dfrm_pkg::ERR_MAGIC);
                  return;
               end
            end
            2: begin
               if (b != version) begin
                  raise_error(dfrm_pkg::ERR_VERSION);
                  return;
               end
            end
            3: held_flags = b;
            4: held_opcode = b;
            5, 6, 7, 8: begin
               if (hdr_pos == 5)
                  length_acc = '0;
               length_acc = length_acc | (32'(b) << (8 * (hdr_pos - 5)));
               // limit applies as it stands when the top length byte lands
               if (hdr_pos == 8 && length_acc > 32'(max_length)) begin
                  raise_error(dfrm_pkg::ERR_LENGTH);
                  return;
               end
            end
            default: ;
         endcase

         if (hdr_pos + 1 >= dfrm_pkg::HEADER_BYTES) begin
            r.kind = dfrm_pkg::KIND_HEADER;
            r.flags = held_flags;
            r.opcode = held_opcode;
            r.length = length_acc[dfrm_pkg::LEN_W-1:0];
            r.last = (length_acc == '0);
            awaited_results.push_back(r);
            header_count++;
            hdr_pos = 0;
            if (!r.last) begin
               state = ST_PAYLOAD;
               remaining = length_acc[dfrm_pkg::LEN_W-1:0];
            end
         end else begin
            hdr_pos++;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void match_result(logic [dfrm_pkg::RSP_TDATA_W-1:0] tdata, logic [1:0] tuser,
                                 logic tlast);
         deframe_result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0h tdata %0h last %0b",
                     $time, tuser, tdata, tlast);
            mismatch_count++;
            return;
         end
         want = awaited_results.pop_front();
         checked_count++;
         compare_field("kind", 32'(want.kind), 32'(tuser));
         compare_field("frame_flags", 32'(want.flags), 32'(tdata[FLAGS_LSB +: 8]));
         compare_field("opcode", 32'(want.opcode), 32'(tdata[OPCODE_LSB +: 8]));
         compare_field("payload_length", 32'(want.length),
                       32'(tdata[LENGTH_LSB +: dfrm_pkg::LEN_W]));
         compare_field("payload_byte", 32'(want.payload_byte), 32'(tdata[PBYTE_LSB +: 8]));
         compare_field("error_code", 32'(want.error_code), 32'(tdata[ECODE_LSB +: 2]));
         compare_field("tdata padding", '0, 32'(tdata[dfrm_pkg::RSP_TDATA_W-1:PAD_LSB]));
         compare_field("last", 32'(want.last), 32'(tlast));
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = 8'h00;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [dfrm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [dfrm_pkg::CSR_IDX_W-1:0]   csr_index  = dfrm_pkg::CSR_MAGIC_FIRST;
   logic [dfrm_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   deframe_scoreboard_type           tracker;
   int unsigned                      cycle_count     = 0;
   int unsigned                      stream_bytes    = 0;
   int unsigned                      sender_idle_pct = 0;
   int unsigned                      stall_pct       = 0;

   int                               phase_no;
   int unsigned                      phase_start;
   logic [7:0]                       new_magic_first;
   logic [7:0]                       new_magic_second;
   logic [7:0]                       new_version;
   logic [dfrm_pkg::CSR_DATA_W-1:0]  new_max;
   logic [31:0]                      first_len;
   logic [31:0]                      over_len;
   byte_q_type                       split_header;
   string                            closing_case;
   bit                               failed;

   length_prefixed_frame_deframer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("length_prefixed_frame_deframer_top_tb: FAIL");
         $finish;
      end
   end

   // Receiver: re-roll backpressure every cycle on the falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Check every result transaction at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Offer one byte, with random sender gaps first, and hold it until the
   // transaction completes. Enter and leave on a falling edge; tvalid stays
   // high on exit so back-to-back bytes need no extra assignment.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.take_byte(b);
      stream_bytes++;
      @(negedge clock);
   endtask

   task automatic send_range(input byte_q_type q, input int from, input int upto);
      for (int i = from; i < upto; i++)
         send_byte(q[i]);
   endtask

   task automatic send_payload(input logic [31:0] len);
      for (int unsigned i = 0; i < len; i++)
         send_byte(8'($urandom));
   endtask

   // Build a header against the magic and version currently programmed.
   function automatic byte_q_type frame_header(logic [7:0] flags, logic [7:0] op,
                                               logic [31:0] len);
      byte_q_type h;
      h = {tracker.magic_first, tracker.magic_second, tracker.version, flags, op,
           len[7:0], len[15:8], len[23:16], len[31:24]};
      return h;
   endfunction

   task automatic send_frame(input logic [7:0] flags, input logic [7:0] op,
                             input logic [31:0] len);
      send_range(frame_header(flags, op, len), 0, dfrm_pkg::HEADER_BYTES);
      send_payload(len);
   endtask

   // Mostly short frames, now and then one at the current limit or 48 bytes, whichever is smaller.
   task automatic send_random_frame();
      logic [31:0] cap;
      logic [31:0] len;
      cap = (tracker.max_length < 20) ? 32'(tracker.max_length) : 32'd20;
      len = $urandom_range(cap);
      if ($urandom_range(7) == 0)
         len = (tracker.max_length < 48) ? 32'(tracker.max_length) : 32'd48;
      send_frame(8'($urandom), 8'($urandom), len);
   endtask

   // Drive the write and wait for the rising edge that takes it; the caller drops csr_we after a burst.
   task automatic write_csr(input logic [dfrm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dfrm_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      while (tracker.awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening on the reset register values: an empty frame
      // (header carries last), all-ones flags, opcode and payload byte, and
      // a two-byte payload of 8'h00 and 8'h80.
      send_frame(8'h00, 8'h00, 32'd0);
      send_range(frame_header(8'hFF, 8'hFF, 32'd1), 0, dfrm_pkg::HEADER_BYTES);
      send_byte(8'hFF);
      send_range(frame_header(8'h5A, 8'hA5, 32'd2), 0, dfrm_pkg::HEADER_BYTES);
      send_byte(8'h00);
      send_byte(8'h80);
      req_tvalid <= 1'b0;
      drain_and_settle();

      for (phase_no = 1; phase_no <= PHASE_COUNT; phase_no++) begin
         // Cycle through: free flow, sparse sender, heavy backpressure, both.
         case ((phase_no - 1) % 4)
            0: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 76;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 76;
            end
            default: begin
               sender_idle_pct = 18;
               stall_pct = 18;
            end
         endcase

         new_magic_first  = 8'($urandom);
         new_magic_second = 8'($urandom);
         new_version      = 8'($urandom);
         case (phase_no)
            1: begin
               new_magic_first  = 8'hFF;
               new_magic_second = 8'hFF;
               new_version      = 8'hFF;
               new_max = '0;
            end
            2: begin
               new_magic_first  = 8'h00;
               new_magic_second = 8'h00;
               new_version      = 8'h00;
               new_max = dfrm_pkg::CSR_DATA_W'(1);
            end
            3: new_max = '1;
            4: new_max = dfrm_pkg::CSR_DATA_W'(3);
            5: new_max = dfrm_pkg::LIMIT_MAX;
            6: new_max = dfrm_pkg::CSR_DATA_W'(16);
            7: new_max = dfrm_pkg::CSR_DATA_W'($urandom_range(64, 1));
            default: new_max = dfrm_pkg::LIMIT_MAX + dfrm_pkg::CSR_DATA_W'(1);
         endcase

         write_csr(dfrm_pkg::CSR_MAGIC_FIRST, dfrm_pkg::CSR_DATA_W'(new_magic_first));
         write_csr(dfrm_pkg::CSR_MAGIC_SECOND, dfrm_pkg::CSR_DATA_W'(new_magic_second));
         write_csr(dfrm_pkg::CSR_VERSION, dfrm_pkg::CSR_DATA_W'(new_version));
         csr_we <= 1'b0;

         // Retune the length limit in the middle of the first header, after
         // the two low length bytes but before the two high ones: the check must use
         // the new value. Small limits get a frame of exactly that length.
         first_len = (new_max != '0 && new_max < 48) ? 32'(new_max) : 32'($urandom_range(20));
         split_header = frame_header(8'($urandom), 8'($urandom), first_len);
         send_range(split_header, 0, 7);
         req_tvalid <= 1'b0;
         drain_and_settle();
         write_csr(dfrm_pkg::CSR_LENGTH_LIMIT, new_max);
         csr_we <= 1'b0;
         send_range(split_header, 7, dfrm_pkg::HEADER_BYTES);
         send_payload(first_len);

         phase_start = stream_bytes;
         while (stream_bytes - phase_start < PHASE_BYTES)
            send_random_frame();
         req_tvalid <= 1'b0;
         drain_and_settle();
      end

      // The error latches until reset, so close the stream with one broken
      // header, then trail noise that must produce nothing.
      case ($urandom_range(3))
         0: begin
            closing_case = "bad first magic byte";
            send_byte(tracker.magic_first ^ 8'($urandom_range(255, 1)));
         end
         1: begin
            closing_case = "bad second magic byte";
            send_byte(tracker.magic_first);
            send_byte(tracker.magic_second ^ 8'($urandom_range(255, 1)));
         end
         2: begin
            closing_case = "bad version";
            send_byte(tracker.magic_first);
            send_byte(tracker.magic_second);
            send_byte(tracker.version ^ 8'($urandom_range(255, 1)));
         end
         default: begin
            closing_case = "length over the limit";
            if ($urandom_range(1) != 0)
               over_len = 32'(tracker.max_length) + 32'd1;
            else
               over_len = {8'($urandom_range(255, 2)), 24'($urandom)};
            send_range(frame_header(8'($urandom), 8'($urandom), over_len), 0,
                       dfrm_pkg::HEADER_BYTES);
         end
      endcase
      repeat (NOISE_BYTES) send_byte(8'($urandom));
      req_tvalid <= 1'b0;
      drain_and_settle();

      failed = (tracker.mismatch_count != 0) || (tracker.awaited_results.size() != 0);
      $display("Streamed %0d bytes: %0d headers completed over %0d register settings,",
               stream_bytes, tracker.header_count, PHASE_COUNT + 1);
      $display("%0d results checked; stream closed on %s.", tracker.checked_count,
               closing_case);
      if (!failed)
         $display("length_prefixed_frame_deframer_top_tb: PASS");
      else
         $display("length_prefixed_frame_deframer_top_tb: FAIL");
      $finish;
   end

endmodule
